@@ hdl/adu_pkg.sv @@
// Shared types, constants and table generator functions for the activation unit.
// Used by adu_interp, adu_finish and activation_and_derivative_unit.
// No dependencies.
package adu_pkg;

  // Function select codes held in the configuration register.
  typedef enum logic [2:0] {
    ACT_IDENTITY = 3'd0,
    ACT_SIGMOID  = 3'd1,
    ACT_TANH     = 3'd2,
    ACT_RELU     = 3'd3,
    ACT_SOFTPLUS = 3'd4
  } act_sel_e;

  // Which constant table a lookup pipeline holds.
  typedef enum logic {
    TAB_SIGMOID = 1'b0,
    TAB_LN1PEXP = 1'b1
  } tab_sel_e;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adu_en_t;

  localparam int          TableDepthDef = 256;
  localparam int          FracBits      = 12;
  localparam int          SpanQ88       = 4096;
  localparam logic [15:0] OneQ15        = 16'h8000;
  localparam logic [63:0] OneQ30        = 64'd1073741824;
  localparam logic [63:0] HalfQ30       = 64'd536870912;

  // Restoring division, evaluated only while the tables are built.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16*g) in Q.30 for g in Q.30 within [0,1].
  function automatic logic [63:0] exp_neg16(input logic [63:0] g);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] e;
    logic        done;
    pos  = OneQ30;
    neg  = '0;
    term = OneQ30;
    done = 1'b0;
    for (int i = 1; i <= 40; i++) begin
      if (!done) begin
        term = (term * g + HalfQ30) >> 30;
        term = div_u64(term, 64'(i));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((i % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    for (int i = 0; i < 4; i++) begin
      e = (e * e + HalfQ30) >> 30;
    end
    return e;
  endfunction

  // ln(1+y) in Q.30 for y in Q.30 within [0,1], via 2*atanh(y/(2+y)).
  function automatic logic [63:0] ln1p_q30(input logic [63:0] y);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z    = div_u64(y << 30, (OneQ30 << 1) + y);
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int i = 1; i < 80; i += 2) begin
      if (term != 64'd0) begin
        sum  = sum + div_u64(term, 64'(i));
        term = (term * z2) >> 30;
      end
    end
    return sum << 1;
  endfunction

  // One table entry in Q1.15 at t = 16*k/depth.
  function automatic logic [15:0] tab_entry(input tab_sel_e sel, input int k, input int depth);
    logic [63:0] g;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] v;
    g   = div_u64(64'(k) << 30, 64'(depth));
    e   = exp_neg16(g);
    den = OneQ30 + e;
    if (sel == TAB_SIGMOID) begin
      v = div_u64((64'd1 << 45) + (den >> 1), den);
    end else begin
      v = (ln1p_q30(e) + (64'd1 << 14)) >> 15;
    end
    if (v > 64'(OneQ15)) begin
      v = 64'(OneQ15);
    end
    return v[15:0];
  endfunction

endpackage

@@ hdl/adu_interp.sv @@
// Three-stage interpolated table lookup: address split, table read, linear step.
// Depends on adu_pkg for the table generator and the stage enable struct.
module adu_interp #(
  parameter int               TableDepth = adu_pkg::TableDepthDef,
  parameter adu_pkg::tab_sel_e TableSel  = adu_pkg::TAB_SIGMOID
) (
  input  logic             clk_i,
  input  adu_pkg::adu_en_t en_i,
  input  logic [17:0]      mag_i,
  output logic [15:0]      val_o
);
  import adu_pkg::*;

  localparam int IdxW = $clog2(TableDepth + 1);
  localparam int PosW = FracBits + IdxW;

  logic [15:0] tab_w [TableDepth+1];

  for (genvar k = 0; k <= TableDepth; k++) begin : g_tab
    localparam logic [15:0] Entry = tab_entry(TableSel, k, TableDepth);
    assign tab_w[k] = Entry;
  end

  // Stage 1: split the magnitude into entry index and fraction.
  logic                sat;
  logic [PosW-1:0]     pos;
  logic [IdxW-1:0]     idx_d, idx_q;
  logic [FracBits-1:0] frac_d, frac1_q, frac2_q;

  assign sat    = (mag_i >= 18'(SpanQ88));
  assign pos    = PosW'(mag_i[FracBits-1:0]) * PosW'(TableDepth);
  assign idx_d  = sat ? IdxW'(TableDepth) : pos[PosW-1:FracBits];
  assign frac_d = sat ? '0 : pos[FracBits-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      idx_q   <= idx_d;
      frac1_q <= frac_d;
    end
  end

  // Stage 2: read the two neighboring entries. The last entry pairs with itself.
  logic [IdxW-1:0] idx_b;
  logic [15:0]     a_q, b_q;

  assign idx_b = (idx_q == IdxW'(TableDepth)) ? idx_q : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      a_q     <= tab_w[idx_q];
      b_q     <= tab_w[idx_b];
      frac2_q <= frac1_q;
    end
  end

  // Stage 3: scaled step between the entries, rounded half up.
  logic        rising;
  logic [15:0] diff;
  logic [28:0] step_prod;
  logic [15:0] step;
  logic [15:0] val_d, val_q;

  assign rising    = (b_q >= a_q);
  assign diff      = rising ? b_q - a_q : a_q - b_q;
  assign step_prod = 29'(diff) * 29'(frac2_q) + 29'd2048;
  assign step      = step_prod[27:12];
  assign val_d     = rising ? a_q + step : a_q - step;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

@@ hdl/adu_finish.sv @@
// Final stage: per-function activation, derivative and unsupported flag.
// Depends on adu_pkg for the select codes and the stage enable struct.
module adu_finish (
  input  logic               clk_i,
  input  adu_pkg::adu_en_t   en_i,
  input  logic signed [15:0] x_i,
  input  logic [2:0]         sel_i,
  input  logic [15:0]        sig_i,
  input  logic [15:0]        lsp_i,
  output logic signed [15:0] act_o,
  output logic [15:0]        der_o,
  output logic               uns_o
);
  import adu_pkg::*;

  // Q1.15 to Q8.8 magnitude, rounding half up on the magnitude.
  function automatic logic [15:0] to_q88(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd64;
    return 16'(t[16:7]);
  endfunction

  logic               neg;
  logic [15:0]        sv;
  logic [16:0]        m_full;
  logic [15:0]        m;
  logic               is_tanh;
  logic [15:0]        mul_a, mul_b;
  logic [31:0]        prod;
  logic [16:0]        prod_r;
  logic signed [15:0] relu;
  logic [16:0]        sp_sum;
  logic [15:0]        r_sv, r_m, r_l;

  logic signed [15:0] act_d, act_q;
  logic [15:0]        der_d, der_q;
  logic               uns_d, uns_q;

  assign neg     = x_i[15];
  assign sv      = neg ? OneQ15 - sig_i : sig_i;
  // For tanh the table is read at twice the magnitude, so the entry is at least one half.
  assign m_full  = {sig_i, 1'b0} - 17'(OneQ15);
  assign m       = m_full[15:0];
  assign is_tanh = (sel_i == ACT_TANH);

  // One shared multiplier: s*(1-s) for sigmoid, m*m for tanh.
  assign mul_a  = is_tanh ? m : sv;
  assign mul_b  = is_tanh ? m : OneQ15 - sv;
  assign prod   = mul_a * mul_b + 32'd16384;
  assign prod_r = prod[31:15];

  assign r_sv   = to_q88(sv);
  assign r_m    = to_q88(m);
  assign r_l    = to_q88(lsp_i);
  assign relu   = neg ? 16'sd0 : x_i;
  assign sp_sum = {1'b0, relu} + {1'b0, r_l};

  always_comb begin
    act_d = '0;
    der_d = '0;
    uns_d = 1'b0;
    unique case (sel_i)
      ACT_IDENTITY: begin
        act_d = x_i;
        der_d = OneQ15;
      end
      ACT_SIGMOID: begin
        act_d = r_sv;
        der_d = prod_r[15:0];
      end
      ACT_TANH: begin
        act_d = neg ? -r_m : r_m;
        der_d = 16'(17'(OneQ15) - prod_r);
      end
      ACT_RELU: begin
        act_d = relu;
        der_d = neg ? 16'd0 : OneQ15;
      end
      ACT_SOFTPLUS: begin
        act_d = (sp_sum > 17'd32767) ? 16'sh7fff : sp_sum[15:0];
        der_d = sv;
      end
      default: begin
        uns_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      act_q <= act_d;
      der_q <= der_d;
      uns_q <= uns_d;
    end
  end

  assign act_o = act_q;
  assign der_o = der_q;
  assign uns_o = uns_q;

endmodule

@@ hdl/activation_and_derivative_unit.sv @@
// Top level of the activation and derivative unit: control, config register, lookups.
// Depends on adu_pkg, adu_interp and adu_finish.
//
// Usage:
//   Input channel: net_input_i (signed Q8.8) with in_valid_i / in_stall_o. A beat is
//   taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel: activation_o (signed Q8.8), derivative_o (unsigned Q1.15) and
//   unsupported_o with out_valid_o / out_stall_i.
//   Config channel: cfg_data_i selects the function (identity, sigmoid, tanh, relu,
//   softplus; other codes flag unsupported). It is always ready; write it while idle.
//   An input beat passes through four stages to its output beat: index split, table
//   read, interpolation, then the per-function stage with its one multiplier. Each
//   stage holds one item; throughput is one beat per cycle unless the output stalls.
//   When the receiver stalls, the output stage holds its beat and bubbles ahead of
//   it still fill, so in_stall_o rises only once all four stages are occupied.
//   Reset clears all valid bits and selects identity. The lookup tables are
//   constants and need no fill after reset.
module activation_and_derivative_unit #(
  parameter int TableDepth = adu_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] net_input_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] activation_o,
  output logic [15:0]        derivative_o,
  output logic               unsupported_o
);
  import adu_pkg::*;

  logic [2:0] sel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= ACT_IDENTITY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sel_q <= cfg_data_i;
    end
  end

  // Stage control: a stage loads when it is empty or the stage after it moves.
  logic    v1_q, v2_q, v3_q, v4_q;
  logic    rdy1, rdy2, rdy3, rdy4;
  adu_en_t en;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Magnitudes for the lookups. Tanh reads the sigmoid table at twice |x|.
  logic signed [16:0] x_ext;
  logic [16:0]        mag;
  logic [17:0]        mag_sig, mag_lsp;

  assign x_ext   = 17'(net_input_i);
  assign mag     = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
  assign mag_sig = (sel_q == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
  assign mag_lsp = {1'b0, mag};

  // Input and select travel alongside the lookup stages.
  logic signed [15:0] x1_q, x2_q, x3_q;
  logic [2:0]         sel1_q, sel2_q, sel3_q;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      x1_q   <= net_input_i;
      sel1_q <= sel_q;
    end
    if (en.s2) begin
      x2_q   <= x1_q;
      sel2_q <= sel1_q;
    end
    if (en.s3) begin
      x3_q   <= x2_q;
      sel3_q <= sel2_q;
    end
  end

  logic [15:0] sig_val, lsp_val;

  adu_interp #(
    .TableDepth (TableDepth),
    .TableSel   (TAB_SIGMOID)
  ) u_sig (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_sig),
    .val_o (sig_val)
  );

  adu_interp #(
    .TableDepth (TableDepth),
    .TableSel   (TAB_LN1PEXP)
  ) u_lsp (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_lsp),
    .val_o (lsp_val)
  );

  adu_finish u_finish (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x3_q),
    .sel_i (sel3_q),
    .sig_i (sig_val),
    .lsp_i (lsp_val),
    .act_o (activation_o),
    .der_o (derivative_o),
    .uns_o (unsupported_o)
  );

  // An unsupported select yields an all-zero result.
  a_uns_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> activation_o == 16'sd0 && derivative_o == 16'd0)
    else $error("unsupported result is not zero");

  // The derivative never exceeds 1.0.
  a_der_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> derivative_o <= OneQ15)
    else $error("derivative above 1.0");

  // Input is held off only when every stage is occupied and the output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q && v4_q && out_stall_i)
    else $error("input stalled with a free stage");

  // A stalled output beat keeps its result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(activation_o) && $stable(derivative_o))
    else $error("stalled result changed");

endmodule

@@ dv/tb_activation_and_derivative_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for activation_and_derivative_unit: directed corners, then random
// net inputs under every select code. Depends on adu_pkg and the unit's RTL only.
import adu_pkg::*;

typedef struct packed {
  logic [15:0] act;
  logic [15:0] der;
  logic        uns;
} adu_result_t;

// Holds the expected result beats and computes them from its own copy of the tables.
class activation_scoreboard #(int Depth = 256);
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam int unsigned One = 32768;

  int unsigned lut[2][Depth+1];
  logic [2:0] func_sel;
  adu_result_t expected_results[$];
  int unsigned errors;
  int unsigned compared;

  function new();
    longint unsigned kk, g, e, den, s, l;
    func_sel = ACT_IDENTITY;
    errors = 0;
    compared = 0;
    for (int k = 0; k <= Depth; k++) begin
      kk = k;
      g = (kk << 30) / Depth;
      e = decay_q30(g);
      den = Q30 + e;
      s = ((64'd1 << 45) + (den >> 1)) / den;
      l = (log1p_q30(e) + (64'd1 << 14)) >> 15;
      lut[TAB_SIGMOID][k] = (s > One) ? One : int'(s);
      lut[TAB_LN1PEXP][k] = (l > One) ? One : int'(l);
    end
  endfunction

  // exp(-16*g) in Q.30: series for exp(-g), then raised to the 16th power by squaring.
  function longint unsigned decay_q30(longint unsigned g);
    longint unsigned up, down, term, e;
    up = Q30;
    down = 0;
    term = Q30;
    for (int i = 1; i <= 40; i++) begin
      term = (term * g + (Q30 >> 1)) >> 30;
      term = term / i;
      if (term == 0) break;
      if (i % 2 == 1) down += term;
      else up += term;
    end
    e = (up > down) ? up - down : 0;
    repeat (4) e = (e * e + (Q30 >> 1)) >> 30;
    return e;
  endfunction

  function longint unsigned log1p_q30(longint unsigned y);
    longint unsigned z, z2, term, sum;
    z = (y << 30) / (2 * Q30 + y);
    z2 = (z * z) >> 30;
    term = z;
    sum = 0;
    for (int i = 1; i < 80 && term != 0; i += 2) begin
      sum += term / i;
      term = (term * z2) >> 30;
    end
    return 2 * sum;
  endfunction

  // Table read with linear interpolation; u is a Q8.8 magnitude.
  function int unsigned interp(tab_sel_e t, int unsigned u);
    int unsigned pos, idx, frac, a, b;
    if (u >= SpanQ88) return lut[t][Depth];
    pos = u * Depth;
    idx = pos >> FracBits;
    frac = pos & ((1 << FracBits) - 1);
    if (idx >= Depth) return lut[t][Depth];
    a = lut[t][idx];
    b = lut[t][idx+1];
    if (b >= a) return a + (((b - a) * frac + 2048) >> FracBits);
    return a - (((a - b) * frac + 2048) >> FracBits);
  endfunction

  function int unsigned sigmoid_q15(int x, int unsigned mag);
    int unsigned s;
    s = interp(TAB_SIGMOID, mag);
    return (x < 0) ? One - s : s;
  endfunction

  function int to_q88(int unsigned m, bit neg);
    int r;
    r = int'((m + 64) >> 7);
    return neg ? -r : r;
  endfunction

  function adu_result_t predict_activation(logic signed [15:0] net);
    int x, act;
    int unsigned mag, der, m;
    adu_result_t r;
    x = net;
    mag = (x < 0) ? -x : x;
    act = 0;
    der = 0;
    r.uns = 1'b0;
    case (func_sel)
      ACT_IDENTITY: begin
        act = x;
        der = One;
      end
      ACT_SIGMOID: begin
        m = sigmoid_q15(x, mag);
        act = to_q88(m, 1'b0);
        der = (m * (One - m) + 16384) >> 15;
      end
      ACT_TANH: begin
        // Magnitude from |x|, sign applied afterwards.
        m = 2 * interp(TAB_SIGMOID, 2 * mag) - One;
        act = to_q88(m, x < 0);
        der = One - ((m * m + 16384) >> 15);
      end
      ACT_RELU: begin
        act = (x < 0) ? 0 : x;
        der = (x < 0) ? 0 : One;
      end
      ACT_SOFTPLUS: begin
        act = ((x < 0) ? 0 : x) + to_q88(interp(TAB_LN1PEXP, mag), 1'b0);
        if (act > 32767) act = 32767;
        der = sigmoid_q15(x, mag);
      end
      default: r.uns = 1'b1;
    endcase
    r.act = act[15:0];
    r.der = der[15:0];
    return r;
  endfunction

  function void set_select(logic [2:0] code);
    func_sel = code;
  endfunction

  function void note_input(logic signed [15:0] net);
    expected_results = {expected_results, predict_activation(net)};
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void flag_mismatch(string field, int expv, int gotv);
    errors++;
    $error("%s mismatch: expected %0d, got %0d", field, expv, gotv);
  endfunction

  function void check_result(logic [15:0] act, logic [15:0] der, logic uns);
    adu_result_t e;
    if (expected_results.size() == 0) begin
      errors++;
      $error("result beat arrived with no input awaiting it");
      return;
    end
    e = expected_results.pop_front();
    compared++;
    if (act !== e.act) flag_mismatch("activation", $signed(e.act), $signed(act));
    if (der !== e.der) flag_mismatch("derivative", e.der, der);
    if (uns !== e.uns) flag_mismatch("unsupported", e.uns, uns);
  endfunction
endclass

module tb_activation_and_derivative_unit;
  localparam int TableDepth = TableDepthDef;
  localparam logic [2:0] SelSpareLo = 3'd5;
  localparam logic [2:0] SelSpareMid = 3'd6;
  localparam logic [2:0] SelSpareHi = 3'd7;
  localparam logic [2:0] AllCodes[8] = '{ACT_IDENTITY, ACT_SIGMOID, ACT_TANH, ACT_RELU,
                                         ACT_SOFTPLUS, SelSpareLo, SelSpareMid, SelSpareHi};
  localparam logic signed [15:0] ExtremeInputs[3] = '{16'sh8000, 16'sh0000, 16'sh7fff};
  localparam int unsigned CornerMags[13] = '{0, 1, 15, 16, 17, 2047, 2048, 2049,
                                             4095, 4096, 4097, 32767, 32768};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] net_input_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] activation_o;
  logic [15:0]        derivative_o;
  logic               unsupported_o;

  logic steady_flow = 1'b0;
  int unsigned beats_in = 0;
  int unsigned pauses = 0;
  activation_scoreboard #(TableDepth) act_sb;

  always #1 clk_i = ~clk_i;

  activation_and_derivative_unit #(.TableDepth(TableDepth)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .net_input_i  (net_input_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .activation_o (activation_o),
    .derivative_o (derivative_o),
    .unsupported_o(unsupported_o)
  );

  // 45% magnitudes to just past the table span, 15% segment and span corners, rest anywhere.
  function automatic logic signed [15:0] draw_net_input(input logic [2:0] code);
    int unsigned roll, span, mag;
    logic signed [15:0] v;
    roll = $urandom_range(0, 99);
    span = (code == ACT_TANH) ? 2100 : 4200;
    if (roll < 45) begin
      mag = $urandom_range(0, span);
    end else if (roll < 60) begin
      mag = CornerMags[$urandom_range(0, 12)];
    end else begin
      v = 16'($urandom);
      return v;
    end
    v = 16'(mag);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_beat(input logic signed [15:0] value, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    net_input_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    act_sb.note_input(value);
    beats_in++;
  endtask

  // Stop sending and wait until every predicted result beat has come back.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (act_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_select(input logic [2:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    act_sb.set_select(code);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act_sb.check_result(activation_o, derivative_o, unsupported_o);
    end
  end

  initial begin : sink
    int unsigned hold;
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [2:0] code;
    act_sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Range ends and zero under every code: saturation beyond the table, ReLU at zero,
    // and the unsupported codes.
    foreach (AllCodes[i]) begin
      quiesce();
      write_select(AllCodes[i]);
      foreach (ExtremeInputs[j]) send_beat(ExtremeInputs[j], $urandom_range(0, 3));
    end

    for (int phase = 0; phase < 13; phase++) begin
      code = (phase < 8) ? AllCodes[phase] : AllCodes[$urandom_range(0, 7)];
      quiesce();
      steady_flow <= (phase % 4 == 3);
      write_select(code);
      for (int k = 0; k < 105; k++) begin
        if (k == 52 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
          quiesce();
          pauses++;
        end
        send_beat(draw_net_input(code), steady_flow ? 0 : $urandom_range(0, 19));
      end
    end

    in_valid_i <= 1'b0;
    steady_flow <= 1'b0;
    for (int c = 0; c < 4000 && act_sb.pending() != 0; c++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (act_sb.pending() != 0) begin
      $error("%0d expected result beats never arrived", act_sb.pending());
      act_sb.errors++;
    end

    $display("Sent %0d input beats under all eight select codes, unsupported ones included,",
             beats_in);
    $display("with %0d drain pauses; %0d result beats were compared.", pauses,
             act_sb.compared);
    if (act_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Timed out waiting for the unit to finish.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
